// ----- rtl/ple_pkg.sv -----
// Types and constants shared by the positional list insert/erase block.
`default_nettype none

package ple_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 8;

    typedef struct packed {
        logic [1:0]        action;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } result_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/positional_list_insert_erase.sv -----
// Top level: ordered list with insert, erase and read at a position.
// The result is strobed on done in the cycle after the command word is taken.
// Throughput: one command word per cycle; busy stays low, every cell updates
// in the same cycle through its neighbor links.
// Reset clears the element count and done; element storage is not cleared.
// The receiver cannot stall; each result word is shown for one cycle.
`default_nettype none

module positional_list_insert_erase #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ple_pkg::cmd_t    cmd,
    output logic                  done,
    output ple_pkg::result_t      result
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > ple_pkg::POS_W) ? LEN_W : ple_pkg::POS_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   done_reg;
    ple_pkg::result_t       result_reg;
    ple_pkg::result_t       result_next;
    ple_pkg::cell_ctrl_t    ctrl;
    logic                   accept;
    logic [CMP_W-1:0]       pos_cmp;
    logic [CMP_W-1:0]       len_cmp;
    logic [1:0]             status;
    logic [DATA_WIDTH-1:0]  sel_data;

    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_cmp = CMP_W'(cmd.position);
    assign len_cmp = CMP_W'(len_reg);

    always_comb
    begin
        priority if (cmd.action == ple_pkg::ACT_INSERT)
        begin
            if (pos_cmp > len_cmp)
                status = ple_pkg::ST_RANGE;
            else if (len_reg == CAP_LEN)
                status = ple_pkg::ST_FULL;
            else
                status = ple_pkg::ST_OK;
        end
        else if (cmd.action == ple_pkg::ACT_ERASE || cmd.action == ple_pkg::ACT_READ)
        begin
            status = (pos_cmp >= len_cmp) ? ple_pkg::ST_RANGE : ple_pkg::ST_OK;
        end
        else
        begin
            status = ple_pkg::ST_RANGE;
        end
    end

    always_comb
    begin
        ctrl.op       = ple_pkg::OP_HOLD;
        ctrl.position = cmd.position;
        ctrl.value    = cmd.value;
        len_next      = len_reg;
        if (accept && status == ple_pkg::ST_OK)
        begin
            if (cmd.action == ple_pkg::ACT_INSERT)
            begin
                ctrl.op  = ple_pkg::OP_INSERT;
                len_next = len_reg + LEN_W'(1);
            end
            else if (cmd.action == ple_pkg::ACT_ERASE)
            begin
                ctrl.op  = ple_pkg::OP_ERASE;
                len_next = len_reg - LEN_W'(1);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
            localparam int RIGHT = (gi == CAPACITY - 1) ? gi : gi + 1;
            ple_cell #(
                .INDEX      (gi),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (cell_data[LEFT]),
                .right_data (cell_data[RIGHT]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // one-hot select of the addressed cell
    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ple_pkg::IDX_W'(cmd.position) == ple_pkg::IDX_W'(i))
                sel_data = sel_data | cell_data[i];
        end
    end

    always_comb
    begin
        result_next.status     = status;
        result_next.read_value = '0;
        if (status == ple_pkg::ST_OK &&
            (cmd.action == ple_pkg::ACT_ERASE || cmd.action == ple_pkg::ACT_READ))
            result_next.read_value = ple_pkg::WORD_W'(sel_data);
        result_next.count    = ple_pkg::CNT_W'(len_next);
        result_next.is_empty = (len_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/ple_cell.sv -----
// One list element cell: holds, loads, or takes a neighbor's element.
`default_nettype none

module ple_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire ple_pkg::cell_ctrl_t    ctrl,
    input  wire logic [DATA_WIDTH-1:0]  left_data,
    input  wire logic [DATA_WIDTH-1:0]  right_data,
    output logic      [DATA_WIDTH-1:0]  data
);

    localparam logic [ple_pkg::IDX_W-1:0] MY_IDX = ple_pkg::IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0]      data_reg;
    logic [DATA_WIDTH-1:0]      data_next;
    logic [ple_pkg::IDX_W-1:0]  pos_ext;

    assign pos_ext = ple_pkg::IDX_W'(ctrl.position);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            ple_pkg::OP_INSERT:
            begin
                if (MY_IDX > pos_ext)
                    data_next = left_data;
                else if (MY_IDX == pos_ext)
                    data_next = DATA_WIDTH'(ctrl.value);
            end
            ple_pkg::OP_ERASE:
            begin
                if (MY_IDX >= pos_ext)
                    data_next = right_data;
            end
            ple_pkg::OP_HOLD:
            begin
                data_next = data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- rtl/ple_checker.sv -----
// Port-level checks for the positional list block, bound to the top level.
`default_nettype none

module ple_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire ple_pkg::cmd_t     cmd,
    input  wire logic              done,
    input  wire ple_pkg::result_t  result
);

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted word produced no result");

    a_done_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted word");

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.count == '0)))
        else $error("empty flag disagrees with count");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ple_pkg::ST_OK) |-> (result.read_value == '0))
        else $error("failed word returned nonzero data");

    a_insert_ok_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.action == ple_pkg::ACT_INSERT) &&
         result.status == ple_pkg::ST_OK) |-> !result.is_empty)
        else $error("successful insert left the list empty");

endmodule

bind positional_list_insert_erase ple_checker u_ple_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ----- bench/positional_list_insert_erase_tb.sv -----
// Testbench for positional_list_insert_erase: directed and random words against a predictor.
module positional_list_insert_erase_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W = 32;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 550;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    ple_pkg::cmd_t cmd = '0;
    logic busy;
    logic done;
    ple_pkg::result_t result;

    positional_list_insert_erase #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [DATA_W-1:0] list_cells [LIST_DEPTH];
    int list_len = 0;

    ple_pkg::cmd_t pending_cmds [$];
    ple_pkg::result_t expected_results [$];
    int cmds_taken = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int gen_len = 0;

    function automatic ple_pkg::result_t list_apply(ple_pkg::cmd_t c);
        ple_pkg::result_t r;
        int i;
        r = '0;
        r.status = ple_pkg::ST_OK;
        case (c.action)
            ple_pkg::ACT_INSERT:
                if (c.position > list_len) r.status = ple_pkg::ST_RANGE;
                else if (list_len >= LIST_DEPTH) r.status = ple_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > c.position; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[c.position] = c.value;
                    list_len++;
                end
            ple_pkg::ACT_ERASE:
                if (c.position >= list_len) r.status = ple_pkg::ST_RANGE;
                else
                begin
                    r.read_value = list_cells[c.position];
                    for (i = c.position; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            ple_pkg::ACT_READ:
                if (c.position >= list_len) r.status = ple_pkg::ST_RANGE;
                else r.read_value = list_cells[c.position];
            default:
                r.status = ple_pkg::ST_RANGE;
        endcase
        r.count = list_len[ple_pkg::CNT_W-1:0];
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    // queue a word and track the element count for stimulus shaping
    task automatic queue_cmd(logic [1:0] act, int pos, logic [ple_pkg::WORD_W-1:0] val);
        ple_pkg::cmd_t c;
        c.action = act;
        c.position = pos[ple_pkg::POS_W-1:0];
        c.value = val;
        pending_cmds.push_back(c);
        if (act == ple_pkg::ACT_INSERT && pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
        else if (act == ple_pkg::ACT_ERASE && pos < gen_len) gen_len--;
    endtask

    function automatic logic [ple_pkg::WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        bit taken;
        bit idle;
        bit drain_hold;
        int idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_results.push_back(list_apply(pending_cmds[0]));
                pending_cmds.pop_front();
                cmds_taken++;
            end
            if (cmds_taken < 190) idle_pct = 37;
            else if (cmds_taken < 380) idle_pct = 61;
            else idle_pct = 0;
            idle = ($urandom_range(0, 99) < idle_pct);
            // let the list settle with nothing in flight
            drain_hold = (cmds_taken == 150 || cmds_taken == 420)
                         && expected_results.size() != 0;
            if (start && !taken)
            begin
                // word not yet taken: hold it
            end
            else if (pending_cmds.size() != 0 && !idle && !drain_hold)
            begin
                start <= 1'b1;
                cmd <= pending_cmds[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_results
        ple_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected result word st=%0d rd=%h cnt=%0d empty=%0d",
                             $realtime, result.status, result.read_value,
                             result.count, result.is_empty);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status || result.read_value !== want.read_value
                    || result.count !== want.count || result.is_empty !== want.is_empty)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"[%0t] mismatch exp st=%0d rd=%h cnt=%0d empty=%0d",
                                  " / got st=%0d rd=%h cnt=%0d empty=%0d"},
                                 $realtime, want.status, want.read_value, want.count,
                                 want.is_empty, result.status, result.read_value,
                                 result.count, result.is_empty);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** positional_list_insert_erase: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int r;
        int pos;
        bit grow;
        logic [1:0] act;

        // empty list cases
        queue_cmd(ple_pkg::ACT_READ, 0, '1);
        queue_cmd(ple_pkg::ACT_ERASE, 0, '0);
        queue_cmd(ple_pkg::ACT_INSERT, 1, 32'h1234_5678);
        queue_cmd(ACT_UNUSED, 0, '0);
        queue_cmd(ple_pkg::ACT_INSERT, 0, '1);
        queue_cmd(ple_pkg::ACT_INSERT, 0, '0);
        // fill up: at the end, at the front, in the middle
        while (gen_len < LIST_DEPTH)
        begin
            case (gen_len % 3)
                0: pos = gen_len;
                1: pos = 0;
                default: pos = gen_len / 2;
            endcase
            queue_cmd(ple_pkg::ACT_INSERT, pos, pick_value());
        end
        // full list
        queue_cmd(ple_pkg::ACT_INSERT, LIST_DEPTH, 32'hA5A5_5A5A);
        queue_cmd(ple_pkg::ACT_INSERT, 0, 32'h5A5A_A5A5);
        queue_cmd(ple_pkg::ACT_INSERT, LIST_DEPTH + 1, '1);
        queue_cmd(ple_pkg::ACT_INSERT, 31, '1);
        queue_cmd(ple_pkg::ACT_READ, LIST_DEPTH - 1, '0);
        queue_cmd(ple_pkg::ACT_READ, LIST_DEPTH, '0);
        queue_cmd(ple_pkg::ACT_READ, 31, '1);
        queue_cmd(ple_pkg::ACT_ERASE, LIST_DEPTH - 1, '0);
        queue_cmd(ple_pkg::ACT_ERASE, 0, '1);
        queue_cmd(ple_pkg::ACT_ERASE, 31, '0);
        queue_cmd(ACT_UNUSED, 31, '1);

        grow = 1'b0;
        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            if (gen_len == LIST_DEPTH) grow = 1'b0;
            else if (gen_len == 0) grow = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                queue_cmd(ACT_UNUSED, $urandom_range(0, 31), pick_value());
            end
            else if (r < 12)
            begin
                act = 2'($urandom_range(0, 2));
                queue_cmd(act, $urandom_range(0, 31), pick_value());
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (grow)
                    act = (r < 55) ? ple_pkg::ACT_INSERT
                        : (r < 75) ? ple_pkg::ACT_ERASE : ple_pkg::ACT_READ;
                else
                    act = (r < 20) ? ple_pkg::ACT_INSERT
                        : (r < 75) ? ple_pkg::ACT_ERASE : ple_pkg::ACT_READ;
                if (gen_len == 0) act = ple_pkg::ACT_INSERT;
                if (act == ple_pkg::ACT_INSERT) pos = $urandom_range(0, gen_len);
                else pos = $urandom_range(0, gen_len - 1);
                queue_cmd(act, pos, pick_value());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("** positional_list_insert_erase: PASSED **");
        else
            $display("** positional_list_insert_erase: FAILED **");
        $finish;
    end

endmodule
